[design/ftlb_pkg.sv]
// Shared types for the fully associative translation buffer.
// Used by ftlb_store, ftlb_rank and fully_assoc_lru_tlb_unit; no dependencies.
`default_nettype none

package ftlb_pkg;

	typedef enum logic [1:0] {
		OP_LOOKUP    = 2'd0,
		OP_ADD       = 2'd1,
		OP_INVAL     = 2'd2,
		OP_INVAL_ALL = 2'd3
	} op_t;

	// Recency update request from the entry store to the rank file.
	typedef struct packed {
		logic promote;   // target was valid: make it most recent
		logic fresh;     // target was free: age every valid entry
		logic remove;    // target leaves the table
		logic clear_all; // drop every entry
	} upd_t;

endpackage

`default_nettype wire

[design/fully_assoc_lru_tlb_unit.sv]
// Fully associative translation buffer with exact LRU replacement: top level.
// Depends on ftlb_pkg, ftlb_store and ftlb_rank.
//
// Each transaction carries an opcode: lookup, add, invalidate one page or
// invalidate all. The input is registered, then the whole lookup and update
// runs on the registered transaction (parallel tag compare over all entries,
// one-hot slot choice, rank update of every entry) and the result lands in an
// output register; one transaction is taken every cycle while the output is
// not stalled. Each result carries the hit/miss totals after that transaction;
// both wrap at 32 bits. Entry contents are never cleared: only the valid bits
// and ranks reset.
`default_nettype none

module fully_assoc_lru_tlb_unit #(
	parameter int ENTRIES   = 16,
	parameter int PAGE_BITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           opcode,
	input  wire logic [PAGE_BITS-1:0] vpn,
	input  wire logic [PAGE_BITS-1:0] new_physical_page,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      hit,
	output logic      [PAGE_BITS-1:0] found_physical_page,
	output logic      [31:0]          hit_total,
	output logic      [31:0]          miss_total
);
	import ftlb_pkg::*;

	logic                 valid_s1;
	op_t                  op_s1;
	logic [PAGE_BITS-1:0] page_s1;
	logic [PAGE_BITS-1:0] frame_s1;
	logic                 valid_s2;
	logic                 hit_s2;
	logic [PAGE_BITS-1:0] found_s2;
	logic [31:0]          hit_cnt_q;
	logic [31:0]          miss_cnt_q;

	logic                 advance;
	logic [ENTRIES-1:0]   valid_vec;
	logic [ENTRIES-1:0]   victim_oh;
	logic [ENTRIES-1:0]   target_oh;
	upd_t                 upd;
	logic                 st_hit;
	logic [PAGE_BITS-1:0] st_frame;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			op_s1    <= op_t'(opcode);
			page_s1  <= vpn;
			frame_s1 <= new_physical_page;
		end
	end

	ftlb_store #(
		.ENTRIES   (ENTRIES),
		.PAGE_BITS (PAGE_BITS)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (advance),
		.op        (op_s1),
		.page      (page_s1),
		.frame_in  (frame_s1),
		.victim_oh (victim_oh),
		.valid     (valid_vec),
		.upd       (upd),
		.target_oh (target_oh),
		.hit       (st_hit),
		.hit_frame (st_frame)
	);

	ftlb_rank #(
		.ENTRIES (ENTRIES)
	) u_rank (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid     (valid_vec),
		.upd       (upd),
		.target_oh (target_oh),
		.victim_oh (victim_oh)
	);

	// Hold the result while stalled; the counters only move on advance too.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else begin
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
			if (advance && (op_s1 == OP_LOOKUP)) begin
				if (st_hit) begin
					hit_cnt_q <= hit_cnt_q + 32'd1;
				end else begin
					miss_cnt_q <= miss_cnt_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_s2   <= st_hit;
			found_s2 <= st_frame;
		end
	end

	assign out_valid           = valid_s2;
	assign hit                 = hit_s2;
	assign found_physical_page = found_s2;
	assign hit_total           = hit_cnt_q;
	assign miss_total          = miss_cnt_q;

endmodule

`default_nettype wire

[design/ftlb_rank.sv]
// Recency rank registers with exact LRU update, one update per cycle.
// Depends on ftlb_pkg for upd_t.
`default_nettype none

module ftlb_rank #(
	parameter int ENTRIES = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [ENTRIES-1:0] valid,
	input  wire ftlb_pkg::upd_t     upd,
	input  wire logic [ENTRIES-1:0] target_oh,
	output logic      [ENTRIES-1:0] victim_oh
);
	import ftlb_pkg::*;

	localparam int RANK_W = $clog2(ENTRIES);
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(ENTRIES - 1);

	logic [RANK_W-1:0] rank_q [ENTRIES];
	logic [RANK_W-1:0] rank_d [ENTRIES];
	logic [RANK_W-1:0] tgt_rank;

	always_comb begin
		tgt_rank = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (target_oh[i]) begin
				tgt_rank = tgt_rank | rank_q[i];
			end
		end
	end

	// A full table holds every rank once, so the oldest entry has the top rank.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			victim_oh[i] = valid[i] && (rank_q[i] == RANK_MAX);
		end
	end

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			rank_d[i] = rank_q[i];
			if (upd.clear_all) begin
				rank_d[i] = '0;
			end else if (target_oh[i] && (upd.promote || upd.fresh || upd.remove)) begin
				rank_d[i] = '0;
			end else if (valid[i] && upd.promote && (rank_q[i] < tgt_rank)) begin
				rank_d[i] = rank_q[i] + RANK_W'(1);
			end else if (valid[i] && upd.fresh) begin
				rank_d[i] = rank_q[i] + RANK_W'(1);
			end else if (valid[i] && upd.remove && (rank_q[i] > tgt_rank)) begin
				rank_d[i] = rank_q[i] - RANK_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= rank_d[i];
			end
		end
	end

endmodule

`default_nettype wire

[design/ftlb_store.sv]
// Entry store: valid bits, tag match, frame read, slot choice and entry writes.
// Depends on ftlb_pkg for op_t and upd_t; victim choice comes from ftlb_rank.
`default_nettype none

module ftlb_store #(
	parameter int ENTRIES   = 16,
	parameter int PAGE_BITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire ftlb_pkg::op_t        op,
	input  wire logic [PAGE_BITS-1:0] page,
	input  wire logic [PAGE_BITS-1:0] frame_in,
	input  wire logic [ENTRIES-1:0]   victim_oh,
	output logic      [ENTRIES-1:0]   valid,
	output ftlb_pkg::upd_t            upd,
	output logic      [ENTRIES-1:0]   target_oh,
	output logic                      hit,
	output logic      [PAGE_BITS-1:0] hit_frame
);
	import ftlb_pkg::*;

	logic [ENTRIES-1:0]   valid_q;
	logic [PAGE_BITS-1:0] tag_q   [ENTRIES];
	logic [PAGE_BITS-1:0] frame_q [ENTRIES];
	logic [ENTRIES-1:0]   match;
	logic [ENTRIES-1:0]   free_oh;
	logic [ENTRIES-1:0]   ins_oh;
	logic [PAGE_BITS-1:0] match_frame;
	logic                 any_match;
	logic                 full;
	logic                 wr_en;

	always_comb begin
		match_frame = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (tag_q[i] == page);
			if (match[i]) begin
				match_frame = match_frame | frame_q[i];
			end
		end
	end

	assign any_match = |match;
	assign full      = &valid_q;
	// Lowest clear bit of the valid vector.
	assign free_oh   = ~valid_q & (valid_q + ENTRIES'(1));
	assign ins_oh    = any_match ? match : (full ? victim_oh : free_oh);

	always_comb begin
		upd       = '0;
		target_oh = match;
		wr_en     = 1'b0;
		case (op)
			OP_LOOKUP: begin
				upd.promote = go && any_match;
			end
			OP_ADD: begin
				target_oh   = ins_oh;
				upd.promote = go && (any_match || full);
				upd.fresh   = go && !any_match && !full;
				wr_en       = go;
			end
			OP_INVAL: begin
				upd.remove = go && any_match;
			end
			OP_INVAL_ALL: begin
				upd.clear_all = go;
			end
			default: begin
				upd = '0;
			end
		endcase
	end

	assign hit       = (op == OP_LOOKUP) && any_match;
	assign hit_frame = hit ? match_frame : '0;
	assign valid     = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (upd.clear_all) begin
			valid_q <= '0;
		end else if (upd.remove) begin
			valid_q <= valid_q & ~match;
		end else if (wr_en) begin
			valid_q <= valid_q | ins_oh;
		end
	end

	// Tags and frames are only read behind a valid bit: no reset.
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (wr_en && ins_oh[i]) begin
				tag_q[i]   <= page;
				frame_q[i] <= frame_in;
			end
		end
	end

endmodule

`default_nettype wire

[dv/tlb_translation_check.sv]
// Result checker for fully_assoc_lru_tlb_unit: watches both channels, keeps a
// shadow LRU translation table and compares each result with its prediction.
// Depends on ftlb_pkg for the opcode type.
`timescale 1ns / 1ps

module tlb_translation_check #(
	parameter int ENTRIES   = 16,
	parameter int PAGE_BITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_stall,
	input  wire logic [1:0]           opcode,
	input  wire logic [PAGE_BITS-1:0] vpn,
	input  wire logic [PAGE_BITS-1:0] new_physical_page,
	input  wire logic                 out_valid,
	input  wire logic                 out_stall,
	input  wire logic                 hit,
	input  wire logic [PAGE_BITS-1:0] found_physical_page,
	input  wire logic [31:0]          hit_total,
	input  wire logic [31:0]          miss_total,
	output int                        mismatches,
	output int                        outstanding
);
	import ftlb_pkg::*;

	typedef struct packed {
		logic                 hit;
		logic [PAGE_BITS-1:0] frame;
		logic [31:0]          hits;
		logic [31:0]          misses;
	} xlat_t;

	bit                   slot_valid [ENTRIES];
	logic [PAGE_BITS-1:0] slot_page  [ENTRIES];
	logic [PAGE_BITS-1:0] slot_frame [ENTRIES];
	int                   slot_age   [ENTRIES];
	logic [31:0]          hit_cnt;
	logic [31:0]          miss_cnt;
	xlat_t                pending_xlat [$];

	function automatic int find_page(input logic [PAGE_BITS-1:0] page);
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i] && slot_page[i] == page)
				return i;
		return -1;
	endfunction

	// Entries newer than the touched one age by one.
	function automatic void make_newest(input int slot);
		int age;
		age = slot_age[slot];
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i] && i != slot && slot_age[i] < age)
				slot_age[i]++;
		slot_age[slot] = 0;
	endfunction

	// Entries older than the removed one move up by one.
	function automatic void retire(input int slot);
		int age;
		age = slot_age[slot];
		slot_valid[slot] = 1'b0;
		slot_age[slot] = 0;
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i] && slot_age[i] > age)
				slot_age[i]--;
	endfunction

	function automatic void install(input logic [PAGE_BITS-1:0] page,
			input logic [PAGE_BITS-1:0] frame);
		int slot;
		slot = find_page(page);
		if (slot >= 0) begin
			slot_frame[slot] = frame;
			make_newest(slot);
			return;
		end
		for (int i = 0; i < ENTRIES && slot < 0; i++)
			if (!slot_valid[i])
				slot = i;
		if (slot < 0) begin
			// evict the oldest, lowest slot on a tie
			slot = 0;
			for (int i = 1; i < ENTRIES; i++)
				if (slot_age[i] > slot_age[slot])
					slot = i;
			retire(slot);
		end
		for (int i = 0; i < ENTRIES; i++)
			if (slot_valid[i])
				slot_age[i]++;
		slot_valid[slot] = 1'b1;
		slot_page[slot]  = page;
		slot_frame[slot] = frame;
		slot_age[slot]   = 0;
	endfunction

	function automatic xlat_t translate(input op_t op, input logic [PAGE_BITS-1:0] page,
			input logic [PAGE_BITS-1:0] frame);
		xlat_t res;
		int    slot;
		res = '0;
		case (op)
			OP_LOOKUP: begin
				slot = find_page(page);
				if (slot >= 0) begin
					res.hit   = 1'b1;
					res.frame = slot_frame[slot];
					make_newest(slot);
					hit_cnt++;
				end else begin
					miss_cnt++;
				end
			end
			OP_ADD: install(page, frame);
			OP_INVAL: begin
				slot = find_page(page);
				if (slot >= 0)
					retire(slot);
			end
			default: begin
				for (int i = 0; i < ENTRIES; i++) begin
					slot_valid[i] = 1'b0;
					slot_age[i]   = 0;
				end
			end
		endcase
		res.hits   = hit_cnt;
		res.misses = miss_cnt;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		xlat_t want;
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_valid[i] = 1'b0;
				slot_page[i]  = '0;
				slot_frame[i] = '0;
				slot_age[i]   = 0;
			end
			hit_cnt  = '0;
			miss_cnt = '0;
			pending_xlat.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_xlat.size() == 0) begin
					$error("result transaction with no prediction waiting");
					mismatches++;
				end else begin
					want = pending_xlat.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d, actual %0d", want.hit, hit);
						mismatches++;
					end
					if (found_physical_page !== want.frame) begin
						$error("found_physical_page: expected %h, actual %h",
							want.frame, found_physical_page);
						mismatches++;
					end
					if (hit_total !== want.hits) begin
						$error("hit_total: expected %0d, actual %0d", want.hits, hit_total);
						mismatches++;
					end
					if (miss_total !== want.misses) begin
						$error("miss_total: expected %0d, actual %0d",
							want.misses, miss_total);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall)
				pending_xlat.push_back(translate(op_t'(opcode), vpn,
					new_physical_page));
			outstanding <= pending_xlat.size();
		end
	end

endmodule

[dv/testbench.sv]
// Top of the translation buffer testbench: clock, reset, stimulus and verdict.
// Instantiates fully_assoc_lru_tlb_unit and tlb_translation_check; uses ftlb_pkg.
`timescale 1ns / 1ps

module testbench;
	import ftlb_pkg::*;

	localparam int ENTRIES     = 16;
	localparam int PAGE_BITS   = 20;
	localparam int RAND_ITEMS  = 1025;
	localparam int CALM_ITEMS  = 150;
	localparam int POOL_SIZE   = 24;
	localparam int HOLD_CYCLES = 60;
	localparam int LIMIT       = 200000;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           opcode = OP_LOOKUP;
	logic [PAGE_BITS-1:0] vpn = '0;
	logic [PAGE_BITS-1:0] new_physical_page = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 hit;
	logic [PAGE_BITS-1:0] found_physical_page;
	logic [31:0]          hit_total;
	logic [31:0]          miss_total;

	int                   mismatches;
	int                   outstanding;
	int unsigned          cycles = 0;
	bit                   gaps_on = 1'b0;
	bit                   hold_req = 1'b0;
	logic [PAGE_BITS-1:0] page_pool [POOL_SIZE];

	fully_assoc_lru_tlb_unit #(
		.ENTRIES(ENTRIES),
		.PAGE_BITS(PAGE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.vpn(vpn),
		.new_physical_page(new_physical_page),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.found_physical_page(found_physical_page),
		.hit_total(hit_total),
		.miss_total(miss_total)
	);

	tlb_translation_check #(
		.ENTRIES(ENTRIES),
		.PAGE_BITS(PAGE_BITS)
	) xlat_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.opcode(opcode),
		.vpn(vpn),
		.new_physical_page(new_physical_page),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.hit(hit),
		.found_physical_page(found_physical_page),
		.hit_total(hit_total),
		.miss_total(miss_total),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Hold valid until the transaction is taken; maybe idle afterwards.
	task automatic issue(input op_t op, input logic [PAGE_BITS-1:0] page,
			input logic [PAGE_BITS-1:0] frame);
		opcode            <= op;
		vpn               <= page;
		new_physical_page <= frame;
		in_valid          <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	initial begin : sender
		logic [PAGE_BITS-1:0] page;
		op_t                  op;
		int                   pick;
		for (int i = 0; i < POOL_SIZE; i++)
			page_pool[i] = PAGE_BITS'($urandom);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, then fill every slot, extremes among the pages
		issue(OP_LOOKUP, '0, '0);
		for (int k = 0; k < ENTRIES; k++) begin
			page = (k == ENTRIES - 1) ? '1 : PAGE_BITS'(k * 'h01111);
			issue(OP_ADD, page, ~page);
		end
		issue(OP_LOOKUP, '0, '1);
		// full table: evicts the oldest, which is page 0x01111 now
		issue(OP_ADD, 20'h5a5a5, 20'ha5a5a);
		issue(OP_LOOKUP, 20'h01111, '0);
		issue(OP_ADD, '0, 20'h12345);
		issue(OP_INVAL, 20'h77777, '1);
		issue(OP_INVAL, '1, '0);
		issue(OP_INVAL_ALL, '0, '1);
		issue(OP_LOOKUP, '0, '0);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			if (n >= RAND_ITEMS - CALM_ITEMS)
				gaps_on = 1'b0;
			else if (n % 64 == 0)
				gaps_on = ($urandom_range(0, 3) != 0);
			if (n == 300)
				hold_req = 1'b1;
			if (n == 600)
				drain_results();
			pick = $urandom_range(0, 99);
			if (pick < 50)
				op = OP_LOOKUP;
			else if (pick < 85)
				op = OP_ADD;
			else if (pick < 97)
				op = OP_INVAL;
			else
				op = OP_INVAL_ALL;
			if ($urandom_range(0, 9) == 0)
				page = PAGE_BITS'($urandom);
			else
				page = page_pool[$urandom_range(0, POOL_SIZE - 1)];
			issue(op, page, PAGE_BITS'($urandom));
		end

		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : receiver
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				// long hold-off so the pipeline fills and stalls the input
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 11)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

endmodule
